// ----- hdl/gprw_pkg.sv -----
`default_nettype none

package gprw_pkg;

  localparam int MUL_W     = 12;
  localparam int MUL_CNT_W = $clog2(MUL_W);
  localparam int STORE_AW  = 14;
  localparam int STORE_DW  = 8;

  localparam int MAX_GLYPH_ROWS  = 32;
  localparam int MAX_GLYPH_WIDTH = 16;

endpackage

`default_nettype wire

// ----- hdl/gprw_serial_mul.sv -----
`default_nettype none

module gprw_serial_mul import gprw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [MUL_W-1:0]   a_i,
  input  wire logic [MUL_W-1:0]   b_i,
  output logic                    done_o,
  output logic [2*MUL_W-1:0]      prod_o
);

  // Shift-and-add multiplier: one multiplier bit is retired per cycle, so the
  // adder is only as wide as the multiplicand.
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_W-1:0]     a_q, a_d;
  logic [MUL_W-1:0]     hi_q, hi_d;
  logic [MUL_W-1:0]     lo_q, lo_d;
  logic [MUL_W:0]       sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = sum[MUL_W:1];
      lo_d  = {sum[0], lo_q[MUL_W-1:1]};
      cnt_d = cnt_q + MUL_CNT_W'(1);
      if (cnt_q == MUL_CNT_W'(MUL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// ----- hdl/gprw_font_store.sv -----
`default_nettype none

module gprw_font_store import gprw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [STORE_AW-1:0] wr_addr_i,
  input  wire logic [STORE_DW-1:0] wr_data_i,
  input  wire logic [STORE_AW-1:0] rd_addr_i,
  output logic      [STORE_DW-1:0] rd_data_o
);

  logic [STORE_DW-1:0] mem [2**STORE_AW];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/glyph_row_pixel_writer.sv -----
// Glyph row pixel writer.
// The input stream carries load and draw transactions, told apart by tuser.
// A load writes one byte of the 16 KiB font store. A draw
// reads the two-byte row word of one glyph row and emits one pixel write on
// the output stream for every set, on-canvas column, in increasing x, with
// tlast on the final one; a row that yields no pixel emits nothing.
// A draw whose row lies below the glyph or whose y is off the canvas is
// accepted and dropped. Any other draw, with font_width taken as at most 16,
// occupies the block for these steps: accepting it, running the bit-serial
// multipliers that form the font address and the row stride canvas_width*y
// (12 steps, then a hand-over of the products), the two registered store
// reads, the column scan at one column per cycle while the receiver keeps up,
// ending the scan and releasing the held final pixel. The next transaction is
// taken as soon as that sequence ends, even while the last pixel still sits in
// the output register.
// When the receiver stalls, the column scan waits as soon as a further pixel
// is found while the output register and the one-pixel hold are both full,
// and the release of the final pixel waits for the output register.
// The configuration channel is always ready; the user must write it only while idle,
// as the block does not enforce it. Reset restores the default canvas and font
// geometry; the font store is not cleared and must be loaded before it is drawn from.
`default_nettype none

module glyph_row_pixel_writer import gprw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [13:0] font_address, [21:14] font_byte, [29:22] char_code,
  // [34:30] glyph_row, [50:35] origin_x, [66:51] origin_y,
  // [90:67] ink_color, [95:91] zero
  input  wire logic [95:0] s_axis_tdata_i,
  // [0] operation
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [23:0] pixel_address, [47:24] pixel_color
  output logic [47:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_RDHI  = 3'd2;
  localparam logic [2:0] ST_RDLO  = 3'd3;
  localparam logic [2:0] ST_RDEND = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;

  localparam logic [1:0] REG_CANVAS_W = 2'd0;
  localparam logic [1:0] REG_CANVAS_H = 2'd1;
  localparam logic [1:0] REG_FONT_W   = 2'd2;
  localparam logic [1:0] REG_FONT_H   = 2'd3;

  localparam logic OP_LOAD = 1'b0;

  logic [2:0]  state_q, state_d;
  logic [11:0] cw_q, cnv_h_q;
  logic [4:0]  fw_q;
  logic [5:0]  fh_q;

  logic [4:0]  row_q, row_d;
  logic [15:0] ox_q, ox_d;
  logic [23:0] color_q, color_d;
  logic [12:0] idx_q, idx_d;
  logic [15:0] word_q, word_d;
  logic [16:0] px_q, px_d;
  logic [23:0] addr_q, addr_d;
  logic [4:0]  col_q, col_d;
  logic [4:0]  w_q, w_d;
  logic        pend_valid_q, pend_valid_d;
  logic [23:0] pend_addr_q, pend_addr_d;
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_addr_q, out_addr_d;
  logic [23:0] out_color_q, out_color_d;
  logic        out_last_q, out_last_d;

  logic [13:0] in_font_addr;
  logic [7:0]  in_font_byte;
  logic [7:0]  in_char;
  logic [4:0]  in_row;
  logic [15:0] in_ox;
  logic [15:0] in_oy;
  logic [23:0] in_color;

  logic [4:0]  w_eff;
  logic [5:0]  h_eff;
  logic [16:0] py;
  logic        row_ok, py_ok;
  logic        hit, out_free;
  logic        mul_start, glyph_done, stride_done;
  logic [2*MUL_W-1:0] glyph_prod, stride_prod;
  logic        store_we;
  logic [STORE_AW-1:0] store_raddr;
  logic [STORE_DW-1:0] store_rdata;

  assign in_font_addr = s_axis_tdata_i[13:0];
  assign in_font_byte = s_axis_tdata_i[21:14];
  assign in_char      = s_axis_tdata_i[29:22];
  assign in_row       = s_axis_tdata_i[34:30];
  assign in_ox        = s_axis_tdata_i[50:35];
  assign in_oy        = s_axis_tdata_i[66:51];
  assign in_color     = s_axis_tdata_i[90:67];

  assign w_eff = (fw_q > 5'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : fw_q;
  assign h_eff = (fh_q > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS) : fh_q;
  assign py     = {in_oy[15], in_oy} + {12'd0, in_row};
  assign row_ok = {1'b0, in_row} < h_eff;
  assign py_ok  = !py[16] && (py[15:0] < {4'd0, cnv_h_q});

  assign hit      = word_q[15] && !px_q[16] && (px_q[15:0] < {4'd0, cw_q});
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign store_raddr     = {idx_q, state_q == ST_RDLO};

  gprw_serial_mul u_glyph_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     ({4'd0, in_char}),
    .b_i     ({6'd0, h_eff}),
    .done_o  (glyph_done),
    .prod_o  (glyph_prod)
  );

  gprw_serial_mul u_stride_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (cw_q),
    .b_i     (py[11:0]),
    .done_o  (stride_done),
    .prod_o  (stride_prod)
  );

  gprw_font_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (store_we),
    .wr_addr_i (in_font_addr),
    .wr_data_i (in_font_byte),
    .rd_addr_i (store_raddr),
    .rd_data_o (store_rdata)
  );

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    ox_d         = ox_q;
    color_d      = color_q;
    idx_d        = idx_q;
    word_d       = word_q;
    px_d         = px_q;
    addr_d       = addr_q;
    col_d        = col_q;
    w_d          = w_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    mul_start    = 1'b0;
    store_we     = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == OP_LOAD) begin
            store_we = 1'b1;
          end else if (row_ok && py_ok) begin
            mul_start = 1'b1;
            row_d     = in_row;
            ox_d      = in_ox;
            color_d   = in_color;
            w_d       = w_eff;
            state_d   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (glyph_done) begin
          idx_d   = glyph_prod[12:0] + {8'd0, row_q};
          addr_d  = stride_prod + {{8{ox_q[15]}}, ox_q};
          px_d    = {ox_q[15], ox_q};
          col_d   = '0;
          state_d = ST_RDHI;
        end
      end
      ST_RDHI: begin
        state_d = ST_RDLO;
      end
      ST_RDLO: begin
        word_d[15:8] = store_rdata;
        state_d      = ST_RDEND;
      end
      ST_RDEND: begin
        word_d[7:0] = store_rdata;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (col_q == w_q) begin
          state_d = ST_FLUSH;
        end else if (!hit || !pend_valid_q || out_free) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_addr_d  = pend_addr_q;
              out_color_d = color_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_addr_d  = addr_q;
          end
          word_d = {word_q[14:0], 1'b0};
          px_d   = px_q + 17'd1;
          addr_d = addr_q + 24'd1;
          col_d  = col_q + 5'd1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_addr_d   = pend_addr_q;
          out_color_d  = color_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cw_q         <= 12'd640;
      cnv_h_q      <= 12'd480;
      fw_q         <= 5'd10;
      fh_q         <= 6'd18;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_CANVAS_W: cw_q    <= cfg_data_i;
          REG_CANVAS_H: cnv_h_q <= cfg_data_i;
          REG_FONT_W:   fw_q    <= cfg_data_i[4:0];
          REG_FONT_H:   fh_q    <= cfg_data_i[5:0];
          default:      cw_q    <= cw_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    ox_q        <= ox_d;
    color_q     <= color_d;
    idx_q       <= idx_d;
    word_q      <= word_d;
    px_q        <= px_d;
    addr_q      <= addr_d;
    col_q       <= col_d;
    w_q         <= w_d;
    pend_addr_q <= pend_addr_d;
    out_addr_q  <= out_addr_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_color_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_pend_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
    else $error("held pixel outside of a column scan");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (col_q <= w_q))
    else $error("column counter ran past the glyph width");

  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && out_free) |=> (state_q == ST_IDLE && !pend_valid_q))
    else $error("final pixel was not released");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (glyph_done || stride_done) |-> (state_q == ST_MUL && glyph_done && stride_done))
    else $error("multiplier finished outside of its phase");
`endif

endmodule

`default_nettype wire
